// File: rtl/core/rigid_frame_transform_top_macros.svh
// Assertion helpers for the frame transform block
`ifndef RIGID_FRAME_TRANSFORM_TOP_MACROS_SVH
`define RIGID_FRAME_TRANSFORM_TOP_MACROS_SVH
// clocked check, off while reset is applied
`define RFT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define RFT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/core/rft_pkg.sv
package rft_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int VAL_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int MODE_W = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_L2W_PT  = 3'd0,
		MODE_L2W_DIR = 3'd1,
		MODE_W2L_PT  = 3'd2,
		MODE_W2L_DIR = 3'd3,
		MODE_DIST    = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_W = 3'd0,
		REG_QUAT_X = 3'd1,
		REG_QUAT_Y = 3'd2,
		REG_QUAT_Z = 3'd3,
		REG_POS_X  = 3'd4,
		REG_POS_Y  = 3'd5,
		REG_POS_Z  = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		MS_LOAD, MS_SHIFT, MS_PROD, MS_SUM, MS_DSTART, MS_DIV, MS_DFIN, MS_IDLE
	} mstate_t;

	typedef struct packed {
		logic ready;
		logic degen;
	} mat_status_t;
endpackage

// File: rtl/core/rft_in_if.sv
interface rft_in_if;
	logic                               valid;
	logic                               ready;
	logic [rft_pkg::MODE_W-1:0]         mode;
	logic signed [rft_pkg::VAL_W-1:0]   in_x;
	logic signed [rft_pkg::VAL_W-1:0]   in_y;
	logic signed [rft_pkg::VAL_W-1:0]   in_z;
	modport source (output valid, mode, in_x, in_y, in_z, input ready);
	modport sink (input valid, mode, in_x, in_y, in_z, output ready);
endinterface

// File: rtl/core/rft_out_if.sv
interface rft_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [rft_pkg::VAL_W-1:0]   out_x;
	logic signed [rft_pkg::VAL_W-1:0]   out_y;
	logic signed [rft_pkg::VAL_W-1:0]   out_z;
	logic [rft_pkg::VAL_W-1:0]          dist_sq;
	logic                               degenerate;
	logic                               saturated;
	modport source (output valid, out_x, out_y, out_z, dist_sq, degenerate, saturated,
		input ready);
	modport sink (input valid, out_x, out_y, out_z, dist_sq, degenerate, saturated,
		output ready);
endinterface

// File: rtl/core/rft_matrix.sv
module rft_matrix #(
	parameter int FRAC_BITS = rft_pkg::FRAC_BITS_DEF,
	parameter int MW = FRAC_BITS + 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              restart,
	input  logic signed [rft_pkg::VAL_W-1:0]  quat [4],
	output logic signed [MW-1:0]              mat [9],
	output rft_pkg::mat_status_t              status
);
	import rft_pkg::*;

	localparam int QB = FRAC_BITS + 2;
	localparam int CW = $clog2(QB);
	localparam logic signed [MW:0] ONE_M = (MW+1)'(1) << FRAC_BITS;

	mstate_t state_q, state_d;

	logic [31:0]        mag_q [4];
	logic               neg_q [4];
	logic signed [31:0] prod_q [10];
	logic [31:0]        n_q;
	logic signed [32:0] num_q [9];
	logic [3:0]         ent_q;
	logic [CW-1:0]      cnt_q;
	logic [31:0]        rem_q;
	logic [QB-1:0]      quo_q;
	logic signed [MW-1:0] mat_q [9];
	logic               degen_q;

	logic               big;
	logic signed [15:0] rr [4];
	logic [31:0]        n_sum;
	logic signed [32:0] num_d [9];
	logic signed [32:0] cur_num;
	logic [32:0]        cur_mag;
	logic [32:0]        trial;
	logic               ge;
	logic               rnd_up;
	logic [QB-1:0]      qfin;
	logic               diag;
	logic signed [MW:0] mval;

	function automatic logic signed [32:0] ext(input logic signed [31:0] v);
		return {v[31], v};
	endfunction

	always_comb begin
		big = 1'b0;
		for (int i = 0; i < 4; i++) begin
			big = big | (|mag_q[i][31:15]);
			rr[i] = neg_q[i] ? -$signed({1'b0, mag_q[i][14:0]})
				: $signed({1'b0, mag_q[i][14:0]});
		end
		// products: ww xx yy zz xy wz xz wy yz wx
		n_sum = 32'(prod_q[0]) + 32'(prod_q[1]) + 32'(prod_q[2]) + 32'(prod_q[3]);
		num_d[0] = ext(prod_q[2]) + ext(prod_q[3]);
		num_d[1] = ext(prod_q[4]) - ext(prod_q[5]);
		num_d[2] = ext(prod_q[6]) + ext(prod_q[7]);
		num_d[3] = ext(prod_q[4]) + ext(prod_q[5]);
		num_d[4] = ext(prod_q[1]) + ext(prod_q[3]);
		num_d[5] = ext(prod_q[8]) - ext(prod_q[9]);
		num_d[6] = ext(prod_q[6]) - ext(prod_q[7]);
		num_d[7] = ext(prod_q[8]) + ext(prod_q[9]);
		num_d[8] = ext(prod_q[1]) + ext(prod_q[2]);
		cur_num = num_q[ent_q];
		cur_mag = cur_num[32] ? 33'(-cur_num) : 33'(cur_num);
		trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
		ge = trial >= {1'b0, n_q};
		rnd_up = {rem_q, 1'b0} >= {1'b0, n_q};
		qfin = quo_q + QB'(rnd_up);
		diag = (ent_q == 4'd0) || (ent_q == 4'd4) || (ent_q == 4'd8);
		if (diag)
			mval = ONE_M - $signed({1'b0, qfin});
		else if (cur_num[32])
			mval = -$signed({1'b0, qfin});
		else
			mval = $signed({1'b0, qfin});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= MS_LOAD;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MS_LOAD:   state_d = MS_SHIFT;
			MS_SHIFT:  state_d = big ? MS_SHIFT : MS_PROD;
			MS_PROD:   state_d = MS_SUM;
			MS_SUM:    state_d = (n_sum == '0) ? MS_IDLE : MS_DSTART;
			MS_DSTART: state_d = MS_DIV;
			MS_DIV:    state_d = (cnt_q == CW'(QB-1)) ? MS_DFIN : MS_DIV;
			MS_DFIN:   state_d = (ent_q == 4'd8) ? MS_IDLE : MS_DSTART;
			MS_IDLE:   state_d = MS_IDLE;
			default:   state_d = MS_LOAD;
		endcase
		if (restart)
			state_d = MS_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degen_q <= 1'b0;
			ent_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				MS_LOAD: begin
					for (int i = 0; i < 4; i++) begin
						neg_q[i] <= quat[i][31];
						mag_q[i] <= quat[i][31] ? 32'(-quat[i]) : 32'(quat[i]);
					end
				end
				MS_SHIFT: begin
					if (big)
						for (int i = 0; i < 4; i++)
							mag_q[i] <= mag_q[i] >> 1;
				end
				MS_PROD: begin
					prod_q[0] <= rr[0] * rr[0];
					prod_q[1] <= rr[1] * rr[1];
					prod_q[2] <= rr[2] * rr[2];
					prod_q[3] <= rr[3] * rr[3];
					prod_q[4] <= rr[1] * rr[2];
					prod_q[5] <= rr[0] * rr[3];
					prod_q[6] <= rr[1] * rr[3];
					prod_q[7] <= rr[0] * rr[2];
					prod_q[8] <= rr[2] * rr[3];
					prod_q[9] <= rr[0] * rr[1];
				end
				MS_SUM: begin
					n_q <= n_sum;
					for (int i = 0; i < 9; i++)
						num_q[i] <= num_d[i];
					ent_q <= '0;
					degen_q <= (n_sum == '0);
					if (n_sum == '0)
						for (int i = 0; i < 9; i++)
							mat_q[i] <= (i % 4 == 0) ? MW'(ONE_M) : '0;
				end
				MS_DSTART: begin
					rem_q <= cur_mag[31:0];
					quo_q <= '0;
					cnt_q <= '0;
				end
				MS_DIV: begin
					rem_q <= ge ? 32'(trial - {1'b0, n_q}) : trial[31:0];
					quo_q <= {quo_q[QB-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
				end
				MS_DFIN: begin
					mat_q[ent_q] <= MW'(mval);
					ent_q <= ent_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign mat = mat_q;
	assign status.ready = (state_q == MS_IDLE) && !restart;
	assign status.degen = degen_q;
endmodule

// File: rtl/core/rft_datapath.sv
module rft_datapath #(
	parameter int FRAC_BITS = rft_pkg::FRAC_BITS_DEF,
	parameter int MW = FRAC_BITS + 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rft_in_if.sink                            in_ch,
	rft_out_if.source                         out_ch,
	input  logic signed [MW-1:0]              mat [9],
	input  logic signed [rft_pkg::VAL_W-1:0]  pos [3],
	input  rft_pkg::mat_status_t              status
);
	import rft_pkg::*;

	localparam int BW = VAL_W + 1;
	localparam int PW = MW + BW;
	localparam int SW = PW + 2;
	localparam int RW = SW - FRAC_BITS + 1;
	localparam int DW = 2 * VAL_W + 2;
	localparam logic [DW-1:0] HALF = DW'(1) << (FRAC_BITS - 1);
	localparam logic signed [RW:0] SMAX = (RW+1)'(33'sh0_7fff_ffff);
	localparam logic signed [RW:0] SMIN = -SMAX - 1;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [MODE_W-1:0] mode_s1, mode_s2, mode_s3, mode_s4;

	logic signed [MW-1:0] coef_s1 [3][3];
	logic signed [BW-1:0] b_s1 [3];
	logic [VAL_W-1:0]     dmag_s1 [3];
	logic signed [PW-1:0] prod_s2 [3][3];
	logic [2*VAL_W-1:0]   sq_s2 [3];
	logic signed [SW-1:0] sum_s3 [3];
	logic [DW-1:0]        dsum_s3;
	logic signed [RW-1:0] rnd_s4 [3];
	logic [VAL_W-1:0]     dist_s4;
	logic                 dsat_s4;
	logic signed [VAL_W-1:0] res_s5 [3];
	logic [VAL_W-1:0]     dist_s5;
	logic                 sat_s5;
	logic                 degen_s5;

	logic signed [MW-1:0] coef_d [3][3];
	logic signed [BW-1:0] b_d [3];
	logic [VAL_W-1:0]     dmag_d [3];
	logic signed [BW-1:0] diff;
	logic                 l2w;
	logic signed [RW-1:0] rnd_d [3];
	logic [SW-1:0]        amag;
	logic [RW-1:0]        qv;
	logic [DW-1:0]        dq;
	logic signed [RW:0]   ext;
	logic signed [VAL_W-1:0] res_d [3];
	logic [VAL_W-1:0]     dist_d;
	logic                 sat_d;
	logic                 lsat;

	assign adv = !v_s5 || out_ch.ready;
	assign in_ch.ready = adv && status.ready;

	always_comb begin
		logic signed [VAL_W-1:0] vin [3];
		vin[0] = in_ch.in_x;
		vin[1] = in_ch.in_y;
		vin[2] = in_ch.in_z;
		l2w = (in_ch.mode == MODE_L2W_PT) || (in_ch.mode == MODE_L2W_DIR);
		for (int i = 0; i < 3; i++) begin
			diff = BW'(vin[i]) - BW'(pos[i]);
			b_d[i] = (in_ch.mode == MODE_W2L_PT) ? diff : BW'(vin[i]);
			dmag_d[i] = diff[BW-1] ? VAL_W'(-diff) : VAL_W'(diff);
			for (int j = 0; j < 3; j++)
				coef_d[i][j] = l2w ? mat[j*3+i] : mat[i*3+j];
		end
	end

	// round half away from zero on the magnitude
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			amag = sum_s3[i][SW-1] ? SW'(-sum_s3[i]) : SW'(sum_s3[i]);
			qv = RW'(amag >> FRAC_BITS) + RW'(amag[FRAC_BITS-1]);
			rnd_d[i] = sum_s3[i][SW-1] ? -$signed(qv) : $signed(qv);
		end
		dq = dsum_s3 >> FRAC_BITS;
	end

	always_comb begin
		sat_d = 1'b0;
		dist_d = '0;
		for (int i = 0; i < 3; i++) begin
			ext = (RW+1)'(rnd_s4[i]) + ((mode_s4 == MODE_L2W_PT) ? (RW+1)'(pos[i]) : '0);
			lsat = 1'b0;
			if (ext > SMAX) begin
				res_d[i] = VAL_W'(SMAX);
				lsat = 1'b1;
			end else if (ext < SMIN) begin
				res_d[i] = VAL_W'(SMIN);
				lsat = 1'b1;
			end else begin
				res_d[i] = VAL_W'(ext);
			end
			if (mode_s4 > MODE_W2L_DIR)
				res_d[i] = '0;
			else
				sat_d = sat_d | lsat;
		end
		if (mode_s4 == MODE_DIST) begin
			dist_d = dist_s4;
			sat_d = dsat_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid && in_ch.ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= in_ch.mode;
			mode_s2 <= mode_s1;
			mode_s3 <= mode_s2;
			mode_s4 <= mode_s3;
			coef_s1 <= coef_d;
			b_s1 <= b_d;
			dmag_s1 <= dmag_d;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++)
					prod_s2[i][j] <= PW'(coef_s1[i][j]) * PW'(b_s1[j]);
				sq_s2[i] <= (2*VAL_W)'(dmag_s1[i]) * (2*VAL_W)'(dmag_s1[i]);
				sum_s3[i] <= SW'(prod_s2[i][0]) + SW'(prod_s2[i][1]) + SW'(prod_s2[i][2]);
			end
			dsum_s3 <= DW'(sq_s2[0]) + DW'(sq_s2[1]) + DW'(sq_s2[2]) + HALF;
			rnd_s4 <= rnd_d;
			dsat_s4 <= |dq[DW-1:VAL_W];
			dist_s4 <= (|dq[DW-1:VAL_W]) ? '1 : dq[VAL_W-1:0];
			res_s5 <= res_d;
			dist_s5 <= dist_d;
			sat_s5 <= sat_d;
			degen_s5 <= status.degen;
		end
	end

	assign out_ch.valid = v_s5;
	assign out_ch.out_x = res_s5[0];
	assign out_ch.out_y = res_s5[1];
	assign out_ch.out_z = res_s5[2];
	assign out_ch.dist_sq = dist_s5;
	assign out_ch.degenerate = degen_s5;
	assign out_ch.saturated = sat_s5;
endmodule

// File: rtl/core/rigid_frame_transform_top.sv
// One item per cycle sustained while out_ch.ready is high and no rebuild is running.
// Output stalls hold the whole five-stage pipe; no item is lost or repeated.
// Writing a quaternion register rebuilds the rotation in a serial divider:
// in_ch.ready is low from the write cycle until that rebuild is complete.
// Asynchronous active-low reset loads the identity frame and starts that rebuild.
module rigid_frame_transform_top #(
	parameter int FRAC_BITS = rft_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rft_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rft_pkg::VAL_W-1:0]         cfg_data,
	rft_in_if.sink                            in_ch,
	rft_out_if.source                         out_ch
);
	import rft_pkg::*;

	localparam int MW = FRAC_BITS + 2;

	logic signed [VAL_W-1:0] quat_q [4];
	logic signed [VAL_W-1:0] pos_q [3];
	logic signed [MW-1:0]    mat [9];
	mat_status_t             status;
	logic                    restart;

	assign restart = cfg_we && (cfg_index <= REG_QUAT_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q[0] <= VAL_W'(1) << FRAC_BITS;
			quat_q[1] <= '0;
			quat_q[2] <= '0;
			quat_q[3] <= '0;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_QUAT_W: quat_q[0] <= cfg_data;
				REG_QUAT_X: quat_q[1] <= cfg_data;
				REG_QUAT_Y: quat_q[2] <= cfg_data;
				REG_QUAT_Z: quat_q[3] <= cfg_data;
				REG_POS_X:  pos_q[0] <= cfg_data;
				REG_POS_Y:  pos_q[1] <= cfg_data;
				REG_POS_Z:  pos_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	rft_matrix #(.FRAC_BITS(FRAC_BITS), .MW(MW)) u_matrix (
		.clk(clk),
		.arst_n(arst_n),
		.restart(restart),
		.quat(quat_q),
		.mat(mat),
		.status(status)
	);

	rft_datapath #(.FRAC_BITS(FRAC_BITS), .MW(MW)) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.mat(mat),
		.pos(pos_q),
		.status(status)
	);
endmodule

// File: rtl/core/rft_checker.sv
`include "rigid_frame_transform_top_macros.svh"
module rft_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_we,
	input logic [rft_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [rft_pkg::VAL_W-1:0]  out_x,
	input logic signed [rft_pkg::VAL_W-1:0]  out_y,
	input logic signed [rft_pkg::VAL_W-1:0]  out_z,
	input logic [rft_pkg::VAL_W-1:0]         dist_sq
);
	import rft_pkg::*;

	// a new orientation must rebuild the matrix before items are taken
	`RFT_ASSERT(a_quat_write_blocks, cfg_we && cfg_index <= REG_QUAT_Z |=> !in_ready, "item taken during rebuild")
	`RFT_ASSERT_ALWAYS(a_dist_excl, out_valid && dist_sq != 0 |-> out_x == 0 && out_y == 0 && out_z == 0, "distance and vector both set")
	`RFT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled result dropped")
endmodule

bind rigid_frame_transform_top rft_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.cfg_we(cfg_we),
	.cfg_index(cfg_index),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_x(out_ch.out_x),
	.out_y(out_ch.out_y),
	.out_z(out_ch.out_z),
	.dist_sq(out_ch.dist_sq)
);
